@@ rtl/jpc_pkg.sv @@
`default_nettype none
package jpc_pkg;
   localparam int FracBitsDefault = 16;
   localparam int TimeBitsDefault = 16;
   localparam int GainBits = 16;
   localparam int TimeSat = 65535;

   typedef enum logic [3:0] {
      PH_STAND   = 4'd0,
      PH_CROUCH  = 4'd1,
      PH_LAUNCH  = 4'd2,
      PH_LIFTOFF = 4'd3,
      PH_ASCENT  = 4'd4,
      PH_APEX    = 4'd5,
      PH_DESCENT = 4'd6,
      PH_LANDING = 4'd7,
      PH_REBOUND = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      CSR_STILL_LIMIT   = 3'd0,
      CSR_SETTLE        = 3'd1,
      CSR_CROUCH_BOUND  = 3'd2,
      CSR_LIFT_OFFSET   = 3'd3,
      CSR_LIFT_GAIN     = 3'd4,
      CSR_LAND_OFFSET   = 3'd5,
      CSR_LAND_GAIN     = 3'd6,
      CSR_TIMEOUT       = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VEL,
      ST_DISP,
      ST_CLASS,
      ST_GAIN,
      ST_FIX,
      ST_OUT
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture input item
      logic do_vel;  // velocity integration term
      logic do_disp; // displacement integration term
      logic do_cls;  // still / extrema / phase decision
      logic do_gain; // gain product
      logic do_fix;  // apply gain product
      logic do_out;  // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_gain;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -36'sh080000000) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/jump_phase_classifier.sv @@
`default_nettype none
// channel | direction | payload
// req     | in        | accel, delta_ms
// rsp     | out       | phase, velocity_out, displacement_out, phase_changed
// csr     | in        | write / index / data, no read-back
// Steps after the input transfer: velocity, displacement, classify, gain, output;
// a liftoff or landing gain adds a fix step before the output step. The next input
// is taken once the block is back in idle, so only one item is in work at a time;
// the integration terms share one multiplier.
// Reset is synchronous, active high, and loads the register defaults.
// Input stalls while an item is in work; a stalled result holds in the result
// register and the next item waits at its output step until that is taken.
module jump_phase_classifier #(
   parameter int FRAC_BITS = jpc_pkg::FracBitsDefault,
   parameter int TIME_BITS = jpc_pkg::TimeBitsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic signed [31:0] req_accel,
   input  wire logic [9:0] req_delta_ms,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [3:0] rsp_phase,
   output logic signed [31:0] rsp_velocity_out,
   output logic signed [31:0] rsp_displacement_out,
   output logic rsp_phase_changed,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import jpc_pkg::*;

   cmd_type cmd;
   status_type status;

   jpc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   jpc_datapath #(.FRAC_BITS(FRAC_BITS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_accel(req_accel), .req_delta_ms(req_delta_ms),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_phase(rsp_phase), .rsp_velocity_out(rsp_velocity_out),
      .rsp_displacement_out(rsp_displacement_out),
      .rsp_phase_changed(rsp_phase_changed)
   );
endmodule
`default_nettype wire

@@ rtl/jpc_ctrl.sv @@
`default_nettype none
module jpc_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   input  wire jpc_pkg::status_type status,
   output jpc_pkg::cmd_type cmd
);
   import jpc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_VEL;
            end
         end
         ST_VEL: begin
            cmd.do_vel = 1'b1;
            state_in = ST_DISP;
         end
         ST_DISP: begin
            cmd.do_disp = 1'b1;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            cmd.do_cls = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.do_gain = 1'b1;
            state_in = status.need_gain ? ST_FIX : ST_OUT;
         end
         ST_FIX: begin
            cmd.do_fix = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait here until the result register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.do_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while busy");
   a_out_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised without finishing");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result dropped");
endmodule
`default_nettype wire

@@ rtl/jpc_datapath.sv @@
`default_nettype none
module jpc_datapath #(
   parameter int FRAC_BITS = jpc_pkg::FracBitsDefault,
   parameter int TIME_BITS = jpc_pkg::TimeBitsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire jpc_pkg::cmd_type cmd,
   output jpc_pkg::status_type status,
   input  wire logic signed [31:0] req_accel,
   input  wire logic [9:0] req_delta_ms,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_data,
   output logic [3:0] rsp_phase,
   output logic signed [31:0] rsp_velocity_out,
   output logic signed [31:0] rsp_displacement_out,
   output logic rsp_phase_changed
);
   import jpc_pkg::*;

   localparam logic [63:0] BigRaw = 64'd9999 << FRAC_BITS;
   localparam logic signed [31:0] Big =
      (BigRaw > 64'd2147483647) ? 32'sh7FFFFFFF : BigRaw[31:0];
   localparam logic [31:0] StillBand = 32'((64'd1 << FRAC_BITS) / 10);
   localparam logic signed [32:0] DipNeg = -33'(((64'd7 << FRAC_BITS) / 100));
   localparam int TickW = TIME_BITS + 1;
   // tick = delta * (unit div 1000) + (delta * (unit mod 1000) + 500) div 1000
   localparam logic [63:0] TickUnit = 64'd1 << TIME_BITS;
   localparam logic [22:0] TickQuot = 23'(TickUnit / 64'd1000);
   localparam logic [9:0] TickRem = 10'(TickUnit % 64'd1000);
   // ceil(2^30 / 1000): exact floor division by 1000 for numerators below 2^20
   localparam logic [20:0] Recip1000 = 21'd1073742;

   // configuration
   logic [7:0] still_limit_ff, settle_ff;
   logic signed [31:0] crouch_ff, lift_off_ff, land_off_ff;
   logic signed [17:0] lift_gain_ff, land_gain_ff;
   logic [15:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         still_limit_ff <= 8'd10;
         settle_ff <= 8'd5;
         crouch_ff <= -32'sd6554;
         lift_off_ff <= '0;
         lift_gain_ff <= '0;
         land_off_ff <= '0;
         land_gain_ff <= '0;
         timeout_ff <= 16'd2000;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STILL_LIMIT:  still_limit_ff <= csr_data[7:0];
            CSR_SETTLE:       settle_ff <= csr_data[7:0];
            CSR_CROUCH_BOUND: crouch_ff <= csr_data;
            CSR_LIFT_OFFSET:  lift_off_ff <= csr_data;
            CSR_LIFT_GAIN:    lift_gain_ff <= csr_data[17:0];
            CSR_LAND_OFFSET:  land_off_ff <= csr_data;
            CSR_LAND_GAIN:    land_gain_ff <= csr_data[17:0];
            CSR_TIMEOUT:      timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // state
   logic signed [31:0] vel_ff, disp_ff, peak_ff, low_ff;
   phase_type phase_ff;
   logic [8:0] still_ff, since_peak_ff, since_low_ff;
   logic [15:0] tip_ff;
   phase_type before_ff;
   logic signed [31:0] accel_ff;
   logic [TickW-1:0] tick_ff;
   logic gain_sel_ff; // 0 liftoff, 1 landing
   logic need_gain_ff;
   logic signed [35:0] gain_term_ff;

   // result register
   logic [3:0] out_phase_ff;
   logic signed [31:0] out_vel_ff, out_disp_ff;
   logic out_changed_ff;

   // shared magnitude multiplier: |x| * m >> shift
   logic [31:0] mul_a;
   logic [TickW-1:0] mul_b;
   logic [31+TickW:0] mul_p;
   logic mul_neg;
   logic signed [31:0] mul_x;

   always_comb begin
      mul_x = cmd.do_vel ? accel_ff : vel_ff;
      mul_neg = mul_x[31];
      mul_a = mul_neg ? 32'(-mul_x) : mul_x;
      mul_b = tick_ff;
      mul_p = mul_a * mul_b;
   end

   logic [31:0] int_mag;
   logic signed [35:0] int_term;
   assign int_mag = 32'(mul_p >> TIME_BITS);
   assign int_term = mul_neg ? -$signed({4'd0, int_mag}) : $signed({4'd0, int_mag});

   // gain multiplier, used once per item at most
   logic signed [31:0] g_x;
   logic signed [17:0] g_g;
   logic [31:0] g_a;
   logic [17:0] g_b;
   logic [49:0] g_p;
   logic g_neg;
   always_comb begin
      g_x = gain_sel_ff ? (low_ff[31] ? 32'(-low_ff) : low_ff) : peak_ff;
      g_g = gain_sel_ff ? land_gain_ff : lift_gain_ff;
      g_a = g_x[31] ? 32'(-g_x) : g_x;
      g_b = g_g[17] ? 18'(-g_g) : g_g;
      g_p = g_a * g_b;
      // |-2^31| as magnitude needs 32 bits unsigned: keep it
      g_neg = (gain_sel_ff ? 1'b0 : g_x[31]) != g_g[17];
      if (gain_sel_ff && low_ff == 32'sh80000000) g_neg = g_g[17];
   end
   logic [33:0] g_mag;
   assign g_mag = 34'(g_p >> GainBits);

   // classification, combinational from state after integration
   logic [31:0] acc_mag;
   logic [8:0] still_n, sp_n, sl_n;
   logic signed [31:0] vel_n, disp_n, peak_n, low_n;
   phase_type ph_n;
   logic [15:0] tip_n;
   logic need_n, gsel_n;
   logic signed [32:0] v2;

   always_comb begin
      acc_mag = accel_ff[31] ? 32'(-accel_ff) : accel_ff;
      vel_n = vel_ff;
      disp_n = disp_ff;
      peak_n = peak_ff;
      low_n = low_ff;
      ph_n = phase_ff;
      tip_n = tip_ff;
      sp_n = since_peak_ff;
      sl_n = since_low_ff;
      need_n = 1'b0;
      gsel_n = 1'b0;
      if (acc_mag <= StillBand) begin
         still_n = (still_ff <= {1'b0, still_limit_ff}) ? still_ff + 9'd1 : still_ff;
      end else begin
         still_n = '0;
      end
      if (still_n >= {1'b0, still_limit_ff}) begin
         vel_n = '0;
         disp_n = '0;
         low_n = Big;
         peak_n = -Big;
         if (ph_n != PH_STAND) begin
            ph_n = PH_STAND;
            tip_n = '0;
         end
      end
      if (vel_n > peak_n) begin
         peak_n = vel_n;
         sp_n = '0;
      end else if (sp_n < {1'b0, settle_ff}) begin
         sp_n = sp_n + 9'd1;
      end
      if (vel_n < low_n) begin
         low_n = vel_n;
         sl_n = '0;
      end else if (sl_n < {1'b0, settle_ff}) begin
         sl_n = sl_n + 9'd1;
      end
      v2 = {vel_n, 1'b0};
      case (ph_n)
         PH_STAND:
            if (vel_n < crouch_ff && sl_n >= {1'b0, settle_ff}) begin
               ph_n = PH_CROUCH; tip_n = '0;
            end
         PH_CROUCH:
            if (vel_n > 0) begin
               ph_n = PH_LAUNCH; tip_n = '0; peak_n = -Big;
            end
         PH_LAUNCH:
            if (vel_n < peak_n && sp_n >= {1'b0, settle_ff}) begin
               if ($signed({disp_n[31], disp_n}) < DipNeg) begin
                  low_n = Big; peak_n = -Big; ph_n = PH_STAND; tip_n = '0;
               end else begin
                  ph_n = PH_LIFTOFF; tip_n = '0;
                  vel_n = sat32(36'(vel_n) + 36'(lift_off_ff));
                  peak_n = sat32(36'(peak_n) + 36'(lift_off_ff));
                  need_n = 1'b1;
               end
            end
         PH_LIFTOFF:
            if (v2 < 33'(peak_n)) begin
               ph_n = PH_ASCENT; tip_n = '0;
            end
         PH_ASCENT:
            if (vel_n < 0) begin
               ph_n = PH_APEX; tip_n = '0; low_n = Big;
            end
         PH_APEX:
            if (v2 < -33'(peak_n)) begin
               ph_n = PH_DESCENT; tip_n = '0;
            end
         PH_DESCENT:
            if (vel_n > low_n && sl_n >= {1'b0, settle_ff}) begin
               ph_n = PH_LANDING; tip_n = '0;
               vel_n = sat32(36'(vel_n) + 36'(land_off_ff));
               low_n = sat32(36'(low_n) + 36'(land_off_ff));
               need_n = 1'b1;
               gsel_n = 1'b1;
            end
         PH_LANDING:
            if (!vel_n[31]) begin
               ph_n = PH_REBOUND; tip_n = '0;
            end
         default:
            if (vel_n == 0) begin
               low_n = Big; peak_n = -Big;
               if (ph_n != PH_STAND) begin
                  ph_n = PH_STAND; tip_n = '0;
               end
            end
      endcase
      if (ph_n != PH_STAND && tip_n > timeout_ff) begin
         ph_n = PH_STAND; tip_n = '0; low_n = Big; peak_n = -Big;
      end
   end

   logic [16:0] tip_sum;
   assign tip_sum = {1'b0, tip_ff} + {7'd0, req_delta_ms};

   logic [19:0] tick_rem_num;
   logic [40:0] tick_rem_p;
   logic [10:0] tick_rem;
   logic [32:0] tick_base;
   logic [33:0] tick_sum;
   logic [TickW-1:0] tick_calc;
   assign tick_rem_num = {10'd0, req_delta_ms} * {10'd0, TickRem} + 20'd500;
   assign tick_rem_p = {21'd0, tick_rem_num} * {20'd0, Recip1000};
   assign tick_rem = tick_rem_p[40:30];
   assign tick_base = {23'd0, req_delta_ms} * {10'd0, TickQuot};
   assign tick_sum = {1'b0, tick_base} + {23'd0, tick_rem};
   assign tick_calc = TickW'(tick_sum);

   logic signed [35:0] gterm;
   assign gterm = g_neg ? -$signed({2'd0, g_mag}) : $signed({2'd0, g_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         disp_ff <= '0;
         peak_ff <= -Big;
         low_ff <= Big;
         phase_ff <= PH_STAND;
         still_ff <= '0;
         since_peak_ff <= 9'd5;
         since_low_ff <= 9'd5;
         tip_ff <= '0;
         need_gain_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            accel_ff <= req_accel;
            tick_ff <= tick_calc;
            before_ff <= phase_ff;
            tip_ff <= tip_sum[16] ? 16'(TimeSat) : tip_sum[15:0];
         end
         if (cmd.do_vel)  vel_ff <= sat32(36'(vel_ff) + int_term);
         if (cmd.do_disp) disp_ff <= sat32(36'(disp_ff) + int_term);
         if (cmd.do_cls) begin
            vel_ff <= vel_n; disp_ff <= disp_n; peak_ff <= peak_n; low_ff <= low_n;
            phase_ff <= ph_n; tip_ff <= tip_n; still_ff <= still_n;
            since_peak_ff <= sp_n; since_low_ff <= sl_n;
            need_gain_ff <= need_n; gain_sel_ff <= gsel_n;
         end
         if (cmd.do_gain) gain_term_ff <= gterm;
         if (cmd.do_fix) begin
            vel_ff <= sat32(36'(vel_ff) + gain_term_ff);
            if (!gain_sel_ff) peak_ff <= sat32(36'(peak_ff) + gain_term_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_out) begin
         out_phase_ff <= phase_ff;
         out_vel_ff <= vel_ff;
         out_disp_ff <= disp_ff;
         out_changed_ff <= (phase_ff != before_ff);
      end
   end

   assign status.need_gain = need_gain_ff;
   assign rsp_phase = out_phase_ff;
   assign rsp_velocity_out = out_vel_ff;
   assign rsp_displacement_out = out_disp_ff;
   assign rsp_phase_changed = out_changed_ff;

   a_vel_zero_still: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_cls && still_n >= {1'b0, still_limit_ff}) |=> disp_ff == 0)
      else $error("still run did not clear displacement");
   a_fix_after_cls: assert property (@(posedge clock) disable iff (reset)
      cmd.do_fix |-> need_gain_ff)
      else $error("gain applied without request");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cmd.do_cls |=> phase_ff <= PH_REBOUND)
      else $error("phase out of range");
endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import jpc_pkg::*;

   localparam longint BigQ = 64'sd9999 <<< 16;
   localparam longint StillBand = (64'sd1 <<< 16) / 10;
   localparam longint DipDepth = (64'sd7 <<< 16) / 100;

   typedef struct {
      logic signed [31:0] accel;
      logic [9:0]         delta_ms;
   } sample_type;

   typedef struct {
      phase_type          phase;
      logic signed [31:0] velocity;
      logic signed [31:0] displacement;
      logic               changed;
   } track_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_accel = 0;
   logic [9:0] req_delta_ms = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [3:0] rsp_phase;
   logic signed [31:0] rsp_velocity_out, rsp_displacement_out;
   logic rsp_phase_changed;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   jump_phase_classifier dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // configuration shadow and tracker state
   longint still_limit, settle, crouch_bound, lift_off, lift_gain;
   longint land_off, land_gain, timeout_ms;
   longint vel, disp, peak_vel, low_vel, still_cnt, since_peak, since_low, t_phase;
   phase_type cur_phase;

   sample_type pending_samples[$];
   track_type expected_tracks[$];
   int errors = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_cycles = 0;
   bit draining = 0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scale_down(longint x, longint k, int sh);
      longint ax, ak, p;
      ax = x < 0 ? -x : x;
      ak = k < 0 ? -k : k;
      p = (ax * ak) >>> sh;
      return ((x < 0) != (k < 0)) ? -p : p;
   endfunction

   task automatic tracker_reset();
      still_limit = 10; settle = 5; crouch_bound = -6554; lift_off = 0; lift_gain = 0;
      land_off = 0; land_gain = 0; timeout_ms = 2000;
      vel = 0; disp = 0; peak_vel = -BigQ; low_vel = BigQ; cur_phase = PH_STAND;
      still_cnt = 0; since_peak = 5; since_low = 5; t_phase = 0;
   endtask

   function automatic void goto_phase(phase_type p);
      cur_phase = p;
      t_phase = 0;
   endfunction

   function automatic void return_to_stand();
      low_vel = BigQ;
      peak_vel = -BigQ;
      if (cur_phase != PH_STAND) goto_phase(PH_STAND);
   endfunction

   function automatic void predict_track(sample_type s);
      longint a, tick, mag;
      phase_type prior;
      track_type t;
      a = s.accel;
      tick = ((longint'(s.delta_ms) <<< 16) + 500) / 1000;
      prior = cur_phase;
      t_phase += s.delta_ms;
      if (t_phase > 65535) t_phase = 65535;
      vel = sat32(vel + scale_down(a, tick, 16));
      disp = sat32(disp + scale_down(vel, tick, 16));
      mag = a < 0 ? -a : a;
      if (mag <= StillBand) begin
         if (still_cnt <= still_limit) still_cnt++;
      end else still_cnt = 0;
      if (still_cnt >= still_limit) begin
         vel = 0;
         disp = 0;
         return_to_stand();
      end
      if (vel > peak_vel) begin
         peak_vel = vel; since_peak = 0;
      end else if (since_peak < settle) since_peak++;
      if (vel < low_vel) begin
         low_vel = vel; since_low = 0;
      end else if (since_low < settle) since_low++;
      case (cur_phase)
         PH_STAND: if (vel < crouch_bound && since_low >= settle) goto_phase(PH_CROUCH);
         PH_CROUCH: if (vel > 0) begin
            goto_phase(PH_LAUNCH); peak_vel = -BigQ;
         end
         PH_LAUNCH: if (vel < peak_vel && since_peak >= settle) begin
            if (disp < -DipDepth) begin
               low_vel = BigQ; peak_vel = -BigQ; goto_phase(PH_STAND);
            end else begin
               goto_phase(PH_LIFTOFF);
               vel = sat32(vel + lift_off);
               peak_vel = sat32(peak_vel + lift_off);
               vel = sat32(vel + scale_down(peak_vel, lift_gain, 16));
               peak_vel = sat32(peak_vel + scale_down(peak_vel, lift_gain, 16));
            end
         end
         PH_LIFTOFF: if (2 * vel < peak_vel) goto_phase(PH_ASCENT);
         PH_ASCENT: if (vel < 0) begin
            goto_phase(PH_APEX); low_vel = BigQ;
         end
         PH_APEX: if (2 * vel < -peak_vel) goto_phase(PH_DESCENT);
         PH_DESCENT: if (vel > low_vel && since_low >= settle) begin
            goto_phase(PH_LANDING);
            vel = sat32(vel + land_off);
            low_vel = sat32(low_vel + land_off);
            mag = low_vel < 0 ? -low_vel : low_vel;
            vel = sat32(vel + scale_down(mag, land_gain, 16));
         end
         PH_LANDING: if (vel >= 0) goto_phase(PH_REBOUND);
         default: if (vel == 0) return_to_stand();
      endcase
      if (cur_phase != PH_STAND && t_phase > timeout_ms) begin
         goto_phase(PH_REBOUND);
         return_to_stand();
      end
      t.phase = cur_phase;
      t.velocity = vel[31:0];
      t.displacement = disp[31:0];
      t.changed = cur_phase != prior;
      expected_tracks.push_back(t);
   endfunction

   task automatic write_reg(csr_index_type idx, longint value);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value[31:0];
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_STILL_LIMIT: still_limit = value & 8'hFF;
         CSR_SETTLE: settle = value & 8'hFF;
         CSR_CROUCH_BOUND: crouch_bound = longint'(signed'(value[31:0]));
         CSR_LIFT_OFFSET: lift_off = longint'(signed'(value[31:0]));
         CSR_LIFT_GAIN: lift_gain = longint'(signed'(value[17:0]));
         CSR_LAND_OFFSET: land_off = longint'(signed'(value[31:0]));
         CSR_LAND_GAIN: land_gain = longint'(signed'(value[17:0]));
         default: timeout_ms = value & 16'hFFFF;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || expected_tracks.size() != 0 || req_valid)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic void add(longint a, int d);
      sample_type s;
      s.accel = a[31:0];
      s.delta_ms = d[9:0];
      pending_samples.push_back(s);
   endfunction

   // a plausible jump with random amplitude: crouch, push, flight, landing, settle
   function automatic void add_jump();
      int amp, d;
      amp = $urandom_range(200000, 2000);
      d = $urandom_range(30, 1);
      repeat ($urandom_range(6, 2)) add($urandom_range(6000, 0) - 3000, d);
      repeat ($urandom_range(8, 3)) add(-amp, d);
      repeat ($urandom_range(12, 4)) add(2 * amp, d);
      repeat ($urandom_range(10, 3)) add(-amp, d);
      repeat ($urandom_range(14, 4)) add(-2 * amp, d);
      repeat ($urandom_range(10, 3)) add(amp, d);
      repeat ($urandom_range(12, 0)) add($urandom_range(12000, 0) - 6000, d);
   endfunction

   function automatic longint rand32();
      return longint'(signed'($urandom()));
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_track('{req_accel, req_delta_ms});
            void'(pending_samples.pop_front());
            gap_left = $urandom_range(17, 0);
            if ($urandom_range(3, 0) == 0) gap_left = 0;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_samples.size() != 0 && gap_left == 0 && !draining) begin
               req_valid <= 1;
               req_accel <= pending_samples[0].accel;
               req_delta_ms <= pending_samples[0].delta_ms;
            end else begin
               req_valid <= 0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      track_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tracks.size() == 0) begin
               $display("%0t: unexpected transfer phase=%0d vel=%0d disp=%0d", $time,
                        rsp_phase, rsp_velocity_out, rsp_displacement_out);
               errors++;
            end else begin
               e = expected_tracks.pop_front();
               if (rsp_phase !== e.phase) begin
                  $display("%0t: phase exp %0d got %0d", $time, e.phase, rsp_phase);
                  errors++;
               end
               if (rsp_velocity_out !== e.velocity) begin
                  $display("%0t: velocity exp %0d got %0d", $time, e.velocity,
                           rsp_velocity_out);
                  errors++;
               end
               if (rsp_displacement_out !== e.displacement) begin
                  $display("%0t: displacement exp %0d got %0d", $time, e.displacement,
                           rsp_displacement_out);
                  errors++;
               end
               if (rsp_phase_changed !== e.changed) begin
                  $display("%0t: phase_changed exp %0b got %0b", $time, e.changed,
                           rsp_phase_changed);
                  errors++;
               end
            end
            stall_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(17, 0);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else rsp_stall <= 0;
      end
   end

   initial begin
      tracker_reset();
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: field extremes and each special case
      add(32'sh7FFFFFFF, 1023);
      add(32'sh7FFFFFFF, 1023);
      add(-64'sd2147483648, 1023);
      add(-64'sd2147483648, 1023);
      add(-64'sd2147483648, 1023);
      add(StillBand, 0);
      add(-StillBand, 1);
      add(StillBand + 1, 500);
      add(0, 0);
      add_jump();
      wait_idle();

      // timeout and still-limit extremes
      write_reg(CSR_TIMEOUT, 0);
      write_reg(CSR_STILL_LIMIT, 0);
      write_reg(CSR_SETTLE, 0);
      add_jump();
      add(-100000, 20);
      wait_idle();
      write_reg(CSR_TIMEOUT, 65535);
      write_reg(CSR_STILL_LIMIT, 255);
      write_reg(CSR_SETTLE, 255);
      repeat (2) add_jump();
      wait_idle();

      // long receiver hold while the sender keeps offering
      write_reg(CSR_STILL_LIMIT, 10);
      write_reg(CSR_SETTLE, 2);
      hold_cycles = 300;
      add_jump();
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph % 4)
            0: begin
               write_reg(CSR_LIFT_GAIN, 131071); write_reg(CSR_LAND_GAIN, -131072);
               write_reg(CSR_LIFT_OFFSET, 32'sh7FFFFFFF); write_reg(CSR_LAND_OFFSET, -64'sd2147483648);
               write_reg(CSR_CROUCH_BOUND, 32'sh7FFFFFFF);
            end
            1: begin
               write_reg(CSR_LIFT_GAIN, -131072); write_reg(CSR_LAND_GAIN, 131071);
               write_reg(CSR_LIFT_OFFSET, -64'sd2147483648); write_reg(CSR_LAND_OFFSET, 32'sh7FFFFFFF);
               write_reg(CSR_CROUCH_BOUND, -64'sd2147483648);
            end
            default: begin
               write_reg(CSR_LIFT_GAIN, $urandom_range(131071, 0) - 65536);
               write_reg(CSR_LAND_GAIN, $urandom_range(131071, 0) - 65536);
               write_reg(CSR_LIFT_OFFSET, $urandom_range(200000, 0) - 100000);
               write_reg(CSR_LAND_OFFSET, $urandom_range(200000, 0) - 100000);
               write_reg(CSR_CROUCH_BOUND, -$urandom_range(20000, 0));
            end
         endcase
         write_reg(CSR_SETTLE, $urandom_range(8, 0));
         write_reg(CSR_STILL_LIMIT, $urandom_range(20, 1));
         write_reg(CSR_TIMEOUT, $urandom_range(4000, 200));
         while (pending_samples.size() < 100) begin
            if ($urandom_range(4, 0) != 0) add_jump();
            else add(rand32(), $urandom_range(1023, 0));
         end
         wait_idle();
      end

      draining = 1;
      wait_idle();
      if (errors == 0) $display("jump_phase_classifier test passed");
      else $display("jump_phase_classifier test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("jump_phase_classifier test failed");
      $finish;
   end
endmodule
